FILE: hw/rtl/ile_pkg.sv
`default_nettype none
package ile_pkg;

  localparam logic [2:0] MODE_INSERT  = 3'd0;
  localparam logic [2:0] MODE_REMOVE  = 3'd1;
  localparam logic [2:0] MODE_READ    = 3'd2;
  localparam logic [2:0] MODE_WRITE   = 3'd3;
  localparam logic [2:0] MODE_SEARCH  = 3'd4;
  localparam logic [2:0] MODE_COMPARE = 3'd5;
  localparam logic [2:0] MODE_SWAP    = 3'd6;
  localparam logic [2:0] MODE_CLEAR   = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int POS_W  = 9;
  localparam int POS2_W = 8;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 9;

  typedef enum logic [2:0] {
    OP_INSERT, OP_REMOVE, OP_READ, OP_WRITE, OP_SEARCH, OP_COMPARE, OP_SWAP, OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [POS_W-1:0]  position;
    logic [POS2_W-1:0] second_position;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_INS_RD, S_INS_WR, S_INS_PUT, S_REM_RD, S_REM_WR,
    S_SRCH_RD, S_SRCH_CHK, S_RD_WAIT, S_SWAP_WR1, S_SWAP_WR2
  } state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ile_front.sv
`default_nettype none
module ile_front #(
  parameter int DW = 32
) (
  input  wire logic                      start,
  input  wire logic                      queue_full,
  input  wire logic [2:0]                mode,
  input  wire logic [ile_pkg::VAL_W-1:0] value_in,
  input  wire logic [ile_pkg::POS_W-1:0] position,
  input  wire logic [ile_pkg::POS2_W-1:0] second_position,
  output logic                           push,
  output ile_pkg::cmd_t                  push_cmd,
  output logic [DW-1:0]                  push_value
);

  always_comb begin
    push = start && !queue_full;
    push_cmd.position = position;
    push_cmd.second_position = second_position;
    // Values are held at the store width, so wider inputs lose their top bits here.
    push_value = DW'(value_in);
    case (mode)
      ile_pkg::MODE_INSERT:  push_cmd.op = ile_pkg::OP_INSERT;
      ile_pkg::MODE_REMOVE:  push_cmd.op = ile_pkg::OP_REMOVE;
      ile_pkg::MODE_READ:    push_cmd.op = ile_pkg::OP_READ;
      ile_pkg::MODE_WRITE:   push_cmd.op = ile_pkg::OP_WRITE;
      ile_pkg::MODE_SEARCH:  push_cmd.op = ile_pkg::OP_SEARCH;
      ile_pkg::MODE_COMPARE: push_cmd.op = ile_pkg::OP_COMPARE;
      ile_pkg::MODE_SWAP:    push_cmd.op = ile_pkg::OP_SWAP;
      default:               push_cmd.op = ile_pkg::OP_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ile_cmd_queue.sv
`default_nettype none
module ile_cmd_queue #(
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ile_pkg::cmd_t push_cmd,
  input  wire logic [DW-1:0] push_value,
  input  wire logic          pop,
  output logic               full,
  output logic               empty,
  output ile_pkg::cmd_t      head_cmd,
  output logic [DW-1:0]      head_value
);

  ile_pkg::cmd_t cmds [2];
  logic [DW-1:0] values [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head_cmd = cmds[rptr];
  assign head_value = values[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      cmds[wptr] <= push_cmd;
      values[wptr] <= push_value;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ile_back.sv
`default_nettype none
module ile_back #(
  parameter int DEPTH = 256,
  parameter int DW = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      queue_empty,
  input  wire ile_pkg::cmd_t             head_cmd,
  input  wire logic [DW-1:0]             head_value,
  output logic                           pop,
  output logic                           done,
  output logic [ile_pkg::VAL_W-1:0]      read_value,
  output logic                           found,
  output logic [1:0]                     status,
  output logic [ile_pkg::LEN_W-1:0]      list_length
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_a;
  logic [DW-1:0] rdata_b;

  ile_pkg::state_t state, state_next;
  ile_pkg::cmd_t   cmd;
  logic [DW-1:0]   val;
  logic [CW-1:0]   len, len_next;
  logic [CW-1:0]   idx, idx_next;

  logic                         done_next;
  logic [ile_pkg::VAL_W-1:0]    read_value_next;
  logic                         found_next;
  logic [1:0]                   status_next;

  logic          re;
  logic [AW-1:0] ra, rb;
  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  logic [PW-1:0] pos_w, pos2_w, len_w, idx_w;

  assign pos_w  = PW'(cmd.position);
  assign pos2_w = PW'(cmd.second_position);
  assign len_w  = PW'(len);
  assign idx_w  = PW'(idx);
  assign pop = (state == ile_pkg::S_IDLE) && !queue_empty;

  always_comb begin
    state_next = state;
    len_next = len;
    idx_next = idx;
    done_next = 1'b0;
    read_value_next = '0;
    found_next = 1'b0;
    status_next = ile_pkg::ST_OK;
    re = 1'b0;
    ra = pos_w[AW-1:0];
    rb = pos2_w[AW-1:0];
    we = 1'b0;
    wa = pos_w[AW-1:0];
    wd = val;
    case (state)
      ile_pkg::S_IDLE: begin
        if (!queue_empty) state_next = ile_pkg::S_DECIDE;
      end
      ile_pkg::S_DECIDE: begin
        state_next = ile_pkg::S_IDLE;
        done_next = 1'b1;
        case (cmd.op)
          ile_pkg::OP_INSERT: begin
            if (len == CW'(DEPTH)) begin
              status_next = ile_pkg::ST_FULL;
            end else if (pos_w > len_w) begin
              status_next = ile_pkg::ST_BAD_INDEX;
            end else begin
              done_next = 1'b0;
              idx_next = len;
              state_next = ile_pkg::S_INS_RD;
            end
          end
          ile_pkg::OP_CLEAR: begin
            len_next = '0;
          end
          ile_pkg::OP_SEARCH: begin
            if (len == '0) begin
              status_next = ile_pkg::ST_EMPTY;
            end else begin
              done_next = 1'b0;
              idx_next = '0;
              state_next = ile_pkg::S_SRCH_RD;
            end
          end
          default: begin
            if (len == '0) begin
              status_next = ile_pkg::ST_EMPTY;
            end else if (pos_w >= len_w ||
                         (cmd.op == ile_pkg::OP_SWAP && pos2_w >= len_w)) begin
              status_next = ile_pkg::ST_BAD_INDEX;
            end else if (cmd.op == ile_pkg::OP_WRITE) begin
              we = 1'b1;
            end else if (cmd.op == ile_pkg::OP_REMOVE) begin
              done_next = 1'b0;
              idx_next = pos_w[CW-1:0];
              state_next = ile_pkg::S_REM_RD;
            end else if (cmd.op == ile_pkg::OP_SWAP) begin
              done_next = 1'b0;
              re = 1'b1;
              state_next = ile_pkg::S_SWAP_WR1;
            end else begin
              done_next = 1'b0;
              re = 1'b1;
              state_next = ile_pkg::S_RD_WAIT;
            end
          end
        endcase
      end
      // Insert walks down from the tail, moving one word up through S_INS_RD and S_INS_WR.
      ile_pkg::S_INS_RD: begin
        if (idx_w > pos_w) begin
          re = 1'b1;
          ra = AW'(idx - 1'b1);
          state_next = ile_pkg::S_INS_WR;
        end else begin
          state_next = ile_pkg::S_INS_PUT;
        end
      end
      ile_pkg::S_INS_WR: begin
        we = 1'b1;
        wa = idx[AW-1:0];
        wd = rdata_a;
        idx_next = idx - 1'b1;
        state_next = ile_pkg::S_INS_RD;
      end
      ile_pkg::S_INS_PUT: begin
        we = 1'b1;
        len_next = len + 1'b1;
        done_next = 1'b1;
        state_next = ile_pkg::S_IDLE;
      end
      ile_pkg::S_REM_RD: begin
        if ((PW'(idx) + 1'b1) < len_w) begin
          re = 1'b1;
          ra = AW'(idx + 1'b1);
          state_next = ile_pkg::S_REM_WR;
        end else begin
          len_next = len - 1'b1;
          done_next = 1'b1;
          state_next = ile_pkg::S_IDLE;
        end
      end
      ile_pkg::S_REM_WR: begin
        we = 1'b1;
        wa = idx[AW-1:0];
        wd = rdata_a;
        idx_next = idx + 1'b1;
        state_next = ile_pkg::S_REM_RD;
      end
      ile_pkg::S_SRCH_RD: begin
        if (idx < len) begin
          re = 1'b1;
          ra = idx[AW-1:0];
          state_next = ile_pkg::S_SRCH_CHK;
        end else begin
          done_next = 1'b1;
          state_next = ile_pkg::S_IDLE;
        end
      end
      ile_pkg::S_SRCH_CHK: begin
        if (rdata_a == val) begin
          found_next = 1'b1;
          done_next = 1'b1;
          state_next = ile_pkg::S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
          state_next = ile_pkg::S_SRCH_RD;
        end
      end
      ile_pkg::S_RD_WAIT: begin
        done_next = 1'b1;
        state_next = ile_pkg::S_IDLE;
        if (cmd.op == ile_pkg::OP_READ) begin
          read_value_next = ile_pkg::VAL_W'(rdata_a);
        end else begin
          found_next = (rdata_a == val);
        end
      end
      ile_pkg::S_SWAP_WR1: begin
        we = 1'b1;
        wd = rdata_b;
        state_next = ile_pkg::S_SWAP_WR2;
      end
      ile_pkg::S_SWAP_WR2: begin
        we = 1'b1;
        wa = pos2_w[AW-1:0];
        wd = rdata_a;
        done_next = 1'b1;
        state_next = ile_pkg::S_IDLE;
      end
      default: begin
        state_next = ile_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ile_pkg::S_IDLE;
      len <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      len <= len_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    read_value <= read_value_next;
    found <= found_next;
    status <= status_next;
    list_length <= ile_pkg::LEN_W'(len_next);
    if (pop) begin
      cmd <= head_cmd;
      val <= head_value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      rdata_a <= mem[ra];
      rdata_b <= mem[rb];
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst) len <= CW'(DEPTH))
    else $error("length above depth");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ile_pkg::S_IDLE)
    else $error("result while command still running");
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == ile_pkg::ST_FULL) |-> len == CW'(DEPTH))
    else $error("full status with room left");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ile_pkg::S_DECIDE)
    else $error("popped command not decoded");

endmodule
`default_nettype wire

FILE: hw/rtl/indexed_list_engine_top.sv
`default_nettype none
// Ordered list of up to DEPTH words held in a single memory with two read ports
// and one write port. A command is taken when start is high and busy is low; up
// to two commands wait in a queue while the back end works, and busy is high only
// when that queue is full. Each command gives one result, shown for one cycle with
// done high; results come in command order and cannot be held off. Clear, write
// and the refused commands finish in the decide state; read and compare go on to
// a read wait state, and swap reads both words and then writes each one back in
// the other's place. Insert and remove move each word with a read state and a
// write state, and insert then puts the new word; search reads and checks each
// word inspected, and a miss ends with one more read state after the last word.
// The shifts and the search move one word at a time through the memory's ports.
module indexed_list_engine_top #(
  parameter int DEPTH = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [2:0]                 mode,
  input  wire logic [ile_pkg::VAL_W-1:0]  value_in,
  input  wire logic [ile_pkg::POS_W-1:0]  position,
  input  wire logic [ile_pkg::POS2_W-1:0] second_position,
  output logic                            done,
  output logic [ile_pkg::VAL_W-1:0]       read_value,
  output logic                            found,
  output logic [1:0]                      status,
  output logic [ile_pkg::LEN_W-1:0]       list_length
);

  logic                  push, pop, q_full, q_empty;
  ile_pkg::cmd_t         push_cmd, head_cmd;
  logic [DATA_WIDTH-1:0] push_value, head_value;

  assign busy = q_full;

  ile_front #(.DW(DATA_WIDTH)) u_front (
    .start(start), .queue_full(q_full), .mode(mode), .value_in(value_in),
    .position(position), .second_position(second_position),
    .push(push), .push_cmd(push_cmd), .push_value(push_value)
  );

  ile_cmd_queue #(.DW(DATA_WIDTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .push_value(push_value),
    .pop(pop), .full(q_full), .empty(q_empty), .head_cmd(head_cmd),
    .head_value(head_value)
  );

  ile_back #(.DEPTH(DEPTH), .DW(DATA_WIDTH)) u_back (
    .clk(clk), .rst(rst), .queue_empty(q_empty), .head_cmd(head_cmd),
    .head_value(head_value), .pop(pop), .done(done), .read_value(read_value),
    .found(found), .status(status), .list_length(list_length)
  );

endmodule
`default_nettype wire
